@@ rtl/csmd_pkg.sv @@
// ============================================================================
// csmd_pkg
// Shared types and constants for the cell set corner distance block.
// ============================================================================
package csmd_pkg;

    // Fixed widths of the external fields.
    localparam int CELL_W      = 10;
    localparam int DIST_OUT_W  = 21;

    // Command queue between the front end and the execution engine.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // Command codes on the cmd port.
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Operations that travel through the queue.
    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    localparam int OP_W = 2;

    // Execution engine states.
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SCAN   = 2'd1,
        BK_DRAIN  = 2'd2,
        BK_FINISH = 2'd3
    } back_state_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

@@ rtl/csmd_ram.sv @@
// ============================================================================
// csmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module csmd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/csmd_queue.sv @@
// ============================================================================
// csmd_queue
// Short show-ahead command queue between the front end and the engine.
// ============================================================================
module csmd_queue
    import csmd_pkg::*;
#(
    parameter int WIDTH = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        status
);

    logic [WIDTH-1:0]   entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign pop_data         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/csmd_front.sv @@
// ============================================================================
// csmd_front
// Command front end: accepts transfers, decodes the command and trims the
// coordinates to the internal width before queuing.
// ============================================================================
module csmd_front
    import csmd_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                  start,
    input  logic [1:0]            cmd,
    input  logic [CELL_W-1:0]     grid_row,
    input  logic [CELL_W-1:0]     grid_col,
    input  q_status_t             q_status,
    output logic                  busy,
    output logic                  push,
    output op_t                   push_op,
    output logic [COORD_BITS-1:0] push_row,
    output logic [COORD_BITS-1:0] push_col
);

    logic accept;
    logic known;

    assign busy   = q_status.full;
    assign accept = start && !busy;

    // The unused command code is accepted and discarded here.
    always_comb
    begin
        known   = 1'b1;
        push_op = OP_LOAD_A;
        case (cmd)
            CMD_LOAD_A:  push_op = OP_LOAD_A;
            CMD_LOAD_B:  push_op = OP_LOAD_B;
            CMD_COMPUTE: push_op = OP_COMPUTE;
            default:     known   = 1'b0;
        endcase
    end

    assign push     = accept && known;
    assign push_row = COORD_BITS'(grid_row);
    assign push_col = COORD_BITS'(grid_col);

endmodule

@@ rtl/csmd_back.sv @@
// ============================================================================
// csmd_back
// Execution engine: stores loaded cells and scans all A-B pairs through a
// four-stage pipeline to find the smallest squared corner distance.
// ============================================================================
module csmd_back
    import csmd_pkg::*;
#(
    parameter int MAX_CELLS  = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_status_t             q_status,
    input  op_t                   q_op,
    input  logic [COORD_BITS-1:0] q_row,
    input  logic [COORD_BITS-1:0] q_col,
    output logic                  pop,
    output logic                  done,
    output logic [DIST_OUT_W-1:0] min_dist_squared,
    output logic                  set_empty,
    output logic                  overflow
);

    localparam int IDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int CELL_B = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 1;

    back_state_t state_reg;
    back_state_t state_next;

    logic [CNT_W-1:0]      count_a_reg;
    logic [CNT_W-1:0]      count_b_reg;
    logic                  ovf_reg;
    logic [IDX_W-1:0]      i_reg;
    logic [IDX_W-1:0]      j_reg;

    logic                  full_a;
    logic                  full_b;
    logic                  last_i;
    logic                  last_j;
    logic                  we_a;
    logic                  we_b;
    logic                  drop;
    logic                  scan_go;
    logic                  issue;
    logic                  finish_empty;
    logic                  finish_scan;

    logic [CELL_B-1:0]     wdata;
    logic [CELL_B-1:0]     rdata_a;
    logic [CELL_B-1:0]     rdata_b;

    logic                  p1_valid_reg;
    logic                  p1_last_reg;
    logic                  p2_valid_reg;
    logic                  p2_last_reg;
    logic [COORD_BITS-1:0] p2_gap_row_reg;
    logic [COORD_BITS-1:0] p2_gap_col_reg;
    logic                  p3_valid_reg;
    logic                  p3_last_reg;
    logic [SQ_W-1:0]       p3_sq_row_reg;
    logic [SQ_W-1:0]       p3_sq_col_reg;
    logic [SUM_W-1:0]      best_reg;
    logic                  first_reg;

    logic [COORD_BITS-1:0] gap_row;
    logic [COORD_BITS-1:0] gap_col;
    logic [SUM_W-1:0]      sum;
    logic [DIST_OUT_W-1:0] dist_sat;

    logic                  done_reg;
    logic [DIST_OUT_W-1:0] dist_reg;
    logic                  empty_reg;
    logic                  ovf_out_reg;

    function automatic logic [COORD_BITS-1:0] axis_gap(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS-1:0] d;
        begin
            d = (a >= b) ? (a - b) : (b - a);
            axis_gap = (d != '0) ? (d - COORD_BITS'(1)) : '0;
        end
    endfunction

    assign full_a = (count_a_reg == CNT_W'(MAX_CELLS));
    assign full_b = (count_b_reg == CNT_W'(MAX_CELLS));
    assign last_i = (CNT_W'(i_reg) == (count_a_reg - CNT_W'(1)));
    assign last_j = (CNT_W'(j_reg) == (count_b_reg - CNT_W'(1)));
    assign wdata  = {q_row, q_col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pop          = 1'b0;
        we_a         = 1'b0;
        we_b         = 1'b0;
        drop         = 1'b0;
        scan_go      = 1'b0;
        issue        = 1'b0;
        finish_empty = 1'b0;
        finish_scan  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop = 1'b1;
                    case (q_op)
                        OP_LOAD_A:
                        begin
                            we_a = !full_a;
                            drop = full_a;
                        end
                        OP_LOAD_B:
                        begin
                            we_b = !full_b;
                            drop = full_b;
                        end
                        OP_COMPUTE:
                        begin
                            if ((count_a_reg == '0) || (count_b_reg == '0))
                            begin
                                finish_empty = 1'b1;
                            end
                            else
                            begin
                                scan_go    = 1'b1;
                                state_next = BK_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                issue = 1'b1;
                if (last_i && last_j)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (p3_valid_reg && p3_last_reg)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                finish_scan = 1'b1;
                state_next  = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    csmd_ram #(
        .WIDTH (CELL_B),
        .DEPTH (MAX_CELLS)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (i_reg),
        .rdata (rdata_a)
    );

    csmd_ram #(
        .WIDTH (CELL_B),
        .DEPTH (MAX_CELLS)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (j_reg),
        .rdata (rdata_b)
    );

    assign gap_row = axis_gap(rdata_a[CELL_B-1:COORD_BITS], rdata_b[CELL_B-1:COORD_BITS]);
    assign gap_col = axis_gap(rdata_a[COORD_BITS-1:0], rdata_b[COORD_BITS-1:0]);
    assign sum     = SUM_W'(p3_sq_row_reg) + SUM_W'(p3_sq_col_reg);
    assign dist_sat = (|(best_reg >> DIST_OUT_W)) ? '1 : DIST_OUT_W'(best_reg);

    // Set counts, overflow flag and the pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            ovf_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
            p3_valid_reg <= 1'b0;
            p3_last_reg  <= 1'b0;
            first_reg    <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (we_a)
            begin
                count_a_reg <= count_a_reg + CNT_W'(1);
            end
            if (we_b)
            begin
                count_b_reg <= count_b_reg + CNT_W'(1);
            end
            if (drop)
            begin
                ovf_reg <= 1'b1;
            end
            if (finish_empty || finish_scan)
            begin
                count_a_reg <= '0;
                count_b_reg <= '0;
                ovf_reg     <= 1'b0;
            end

            p1_valid_reg <= issue;
            p1_last_reg  <= issue && last_i && last_j;
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            p3_valid_reg <= p2_valid_reg;
            p3_last_reg  <= p2_last_reg;

            if (scan_go)
            begin
                first_reg <= 1'b1;
            end
            else if (p3_valid_reg)
            begin
                first_reg <= 1'b0;
            end

            done_reg <= finish_empty || finish_scan;
        end
    end

    // Scan indices, datapath and result payload.
    always_ff @(posedge clk)
    begin
        if (scan_go)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (issue)
        begin
            if (last_j)
            begin
                j_reg <= '0;
                i_reg <= i_reg + IDX_W'(1);
            end
            else
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
        end

        p2_gap_row_reg <= gap_row;
        p2_gap_col_reg <= gap_col;
        p3_sq_row_reg  <= p2_gap_row_reg * p2_gap_row_reg;
        p3_sq_col_reg  <= p2_gap_col_reg * p2_gap_col_reg;

        if (p3_valid_reg && (first_reg || (sum < best_reg)))
        begin
            best_reg <= sum;
        end

        if (finish_empty)
        begin
            dist_reg    <= '0;
            empty_reg   <= 1'b1;
            ovf_out_reg <= ovf_reg;
        end
        else if (finish_scan)
        begin
            dist_reg    <= dist_sat;
            empty_reg   <= 1'b0;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign done             = done_reg;
    assign min_dist_squared = dist_reg;
    assign set_empty        = empty_reg;
    assign overflow         = ovf_out_reg;

endmodule

@@ rtl/cell_set_corner_min_distance.sv @@
// ============================================================================
// cell_set_corner_min_distance
// Smallest squared corner-to-corner distance between two sets of grid cells.
// ============================================================================
// Usage: a command transfer is taken at a rising edge where start is high and
// busy is low. Command 0 appends (grid_row, grid_col) to set A, command 1
// appends it to set B, command 2 computes the result and clears both sets and
// the overflow flag. The unused command code is taken and ignored.
// Loads into a full set are dropped and remembered in the overflow flag.
// Each compute produces one result that is shown for a single cycle with done
// high; the receiver cannot stall it, so it must capture it in that cycle.
// Throughput: commands sit in a four-entry queue, and loads drain from it at
// one per cycle while the engine is idle, so a stream of loads runs at one
// transfer per cycle. A compute occupies the engine from leaving the queue
// to done: one RAM read of each set per cycle, then three pipeline stages
// (gap, square, compare) and a result register. With either set empty the
// engine takes the command and done follows in the next cycle.
// busy rises only while the queue is full behind a running compute.
// Reset clears the queue, both set counts and the overflow flag; the cell
// RAMs need no clearing since only entries below the counts are read.
// ============================================================================
module cell_set_corner_min_distance
    import csmd_pkg::*;
#(
    parameter int MAX_CELLS  = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            cmd,
    input  logic [CELL_W-1:0]     grid_row,
    input  logic [CELL_W-1:0]     grid_col,
    output logic                  done,
    output logic [DIST_OUT_W-1:0] min_dist_squared,
    output logic                  set_empty,
    output logic                  overflow
);

    // A queue entry carries the decoded operation and the trimmed cell.
    localparam int ENTRY_W = OP_W + 2 * COORD_BITS;

    q_status_t             q_status;
    logic                  push;
    op_t                   push_op;
    logic [COORD_BITS-1:0] push_row;
    logic [COORD_BITS-1:0] push_col;
    logic                  pop;
    logic [ENTRY_W-1:0]    pop_data;
    op_t                   q_op;
    logic [COORD_BITS-1:0] q_row;
    logic [COORD_BITS-1:0] q_col;

    // Front end: takes every transfer that the queue has room for.
    csmd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .start    (start),
        .cmd      (cmd),
        .grid_row (grid_row),
        .grid_col (grid_col),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .push_op  (push_op),
        .push_row (push_row),
        .push_col (push_col)
    );

    // The queue decouples the front end from the engine, so loads keep
    // arriving while a compute is scanning.
    csmd_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_op, push_row, push_col}),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    assign q_op  = op_t'(pop_data[ENTRY_W-1 -: OP_W]);
    assign q_row = pop_data[2*COORD_BITS-1 -: COORD_BITS];
    assign q_col = pop_data[COORD_BITS-1:0];

    // Engine: executes each load as it leaves the queue and computes over all pairs.
    csmd_back #(
        .MAX_CELLS  (MAX_CELLS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .q_op             (q_op),
        .q_row            (q_row),
        .q_col            (q_col),
        .pop              (pop),
        .done             (done),
        .min_dist_squared (min_dist_squared),
        .set_empty        (set_empty),
        .overflow         (overflow)
    );

endmodule

@@ rtl/csmd_checker.sv @@
// ============================================================================
// csmd_checker
// Port-level checks for the cell set corner distance block.
// ============================================================================
module csmd_checker
    import csmd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            cmd,
    input logic                  done,
    input logic [DIST_OUT_W-1:0] min_dist_squared,
    input logic                  set_empty
);

    // Computes taken but not yet answered: at most a full queue plus one.
    logic [Q_CNT_W:0] pending_reg;
    logic             compute_in;

    assign compute_in = start && !busy && (cmd == CMD_COMPUTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (compute_in && !done)
        begin
            pending_reg <= pending_reg + (Q_CNT_W+1)'(1);
        end
        else if (done && !compute_in)
        begin
            pending_reg <= pending_reg - (Q_CNT_W+1)'(1);
        end
    end

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pending_reg != '0))
        else $error("result without an outstanding compute");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= (Q_CNT_W+1)'(Q_DEPTH + 1))
        else $error("more computes outstanding than the queue can hold");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && set_empty) |-> (min_dist_squared == '0))
        else $error("empty-set result carries a nonzero distance");

    a_reset_not_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> !busy)
        else $error("busy right after reset");

endmodule

bind cell_set_corner_min_distance csmd_checker u_csmd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .done             (done),
    .min_dist_squared (min_dist_squared),
    .set_empty        (set_empty)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the grid cell set corner distance block.
// ============================================================================
// Cells are loaded into sets A and B, and compute commands are issued through
// the start/busy handshake. An in-bench model of the two sets predicts every
// compute result, and each done strobe is checked against the oldest
// prediction. A short directed list covers the empty-set cases, the
// coordinate extremes, touching and coincident cells and the ignored command
// code. Random batches with clustered coordinates follow. The last part loads
// set A past capacity and scans the full set against a small set B.
// ============================================================================
module tb
    import csmd_pkg::*;
();

    // Set capacity used both for the instance and for the model below.
    localparam int CELL_CAP = 256;

    // The fourth command code is taken by the block but has no effect.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [CELL_W-1:0] COORD_TOP = {CELL_W{1'b1}};
    localparam longint DIST_SAT = (64'd1 << DIST_OUT_W) - 1;

    // One compute result, as the block reports it.
    typedef struct packed {
        logic [DIST_OUT_W-1:0] dist_sq;
        logic                  empty;
        logic                  ovf;
    } dist_result_t;

    // One row of the directed list. Rows with a typed result carry the value
    // that the compute must give; all other rows rely on the model.
    typedef struct packed {
        logic [1:0]            op;
        logic [CELL_W-1:0]     row;
        logic [CELL_W-1:0]     col;
        bit                    typed;
        logic [DIST_OUT_W-1:0] dist_sq;
        bit                    empty;
        bit                    ovf;
    } stim_row_t;

    localparam int N_ROWS = 25;

    // Extremes of the grid are 0 and 1023, so opposite corners of the grid
    // are 1022 apart on both axes: 2 * 1022 * 1022 = 2088968.
    localparam stim_row_t STIM_ROWS [N_ROWS] = '{
        // Compute straight out of reset: both sets are empty.
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd0,       1'b1, 1'b0},
        // Only set A holds a cell.
        '{CMD_LOAD_A,  10'd0,    10'd0,    1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd0,       1'b1, 1'b0},
        // Only set B holds a cell.
        '{CMD_LOAD_B,  10'd1023, 10'd1023, 1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd0,       1'b1, 1'b0},
        // Opposite corners of the grid.
        '{CMD_LOAD_A,  10'd0,    10'd0,    1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_B,  10'd1023, 10'd1023, 1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd1023, 10'd1023, 1'b1, 21'd2088968, 1'b0, 1'b0},
        // The other diagonal of the grid.
        '{CMD_LOAD_A,  10'd1023, 10'd0,    1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_B,  10'd0,    10'd1023, 1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd2088968, 1'b0, 1'b0},
        // Diagonal neighbors share a corner.
        '{CMD_LOAD_A,  10'd512,  10'd300,  1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_B,  10'd513,  10'd301,  1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd0,       1'b0, 1'b0},
        // The same cell in both sets, with the unused code in between.
        '{CMD_LOAD_A,  10'd100,  10'd100,  1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_B,  10'd100,  10'd100,  1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_UNUSED,  10'd1023, 10'd1023, 1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd0,       1'b0, 1'b0},
        // The unused code alone must not load anything.
        '{CMD_UNUSED,  10'd0,    10'd0,    1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b1, 21'd0,       1'b1, 1'b0},
        // Two cells per set; the nearest pair is not the first pair.
        '{CMD_LOAD_A,  10'd10,   10'd20,   1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_A,  10'd700,  10'd3,    1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_B,  10'd690,  10'd9,    1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_LOAD_B,  10'd14,   10'd25,   1'b0, 21'd0,       1'b0, 1'b0},
        '{CMD_COMPUTE, 10'd0,    10'd0,    1'b0, 21'd0,       1'b0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            cmd = CMD_LOAD_A;
    logic [CELL_W-1:0]     grid_row = '0;
    logic [CELL_W-1:0]     grid_col = '0;
    logic                  done;
    logic [DIST_OUT_W-1:0] min_dist_squared;
    logic                  set_empty;
    logic                  overflow;

    // Model state: the two cell sets, their fill levels and the drop flag.
    logic [CELL_W-1:0] set_a_row [CELL_CAP];
    logic [CELL_W-1:0] set_a_col [CELL_CAP];
    logic [CELL_W-1:0] set_b_row [CELL_CAP];
    logic [CELL_W-1:0] set_b_col [CELL_CAP];
    int                fill_a = 0;
    int                fill_b = 0;
    bit                load_dropped = 1'b0;

    // Predicted compute results, oldest first.
    dist_result_t pending_results [$];

    int error_count = 0;
    int cells_and_computes = 0;

    cell_set_corner_min_distance #(
        .MAX_CELLS  (CELL_CAP),
        .COORD_BITS (CELL_W)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .grid_row         (grid_row),
        .grid_col         (grid_col),
        .done             (done),
        .min_dist_squared (min_dist_squared),
        .set_empty        (set_empty),
        .overflow         (overflow)
    );

    always #5 clk = ~clk;

    // Hard stop well beyond the slowest correct run, which is dominated by the
    // over-capacity scan and the long idle gaps of the second phase.
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Squared gap between the nearest corners of two cells along one axis.
    function automatic longint corner_gap_sq(input logic [CELL_W-1:0] p,
                                             input logic [CELL_W-1:0] q);
        longint d;
        d = (p >= q) ? longint'(p - q) : longint'(q - p);
        d = (d > 0) ? d - 1 : 0;
        return d * d;
    endfunction

    // Smallest corner distance over all A-B pairs of the current sets.
    function automatic dist_result_t nearest_corner_sq();
        dist_result_t res;
        longint       best;
        longint       d;
        res.empty = (fill_a == 0) || (fill_b == 0);
        res.ovf   = load_dropped;
        best      = 0;
        if (!res.empty)
        begin
            best = -1;
            for (int i = 0; i < fill_a; i++)
            begin
                for (int j = 0; j < fill_b; j++)
                begin
                    d = corner_gap_sq(set_a_row[i], set_b_row[j])
                        + corner_gap_sq(set_a_col[i], set_b_col[j]);
                    if (best < 0 || d < best)
                        best = d;
                end
            end
        end
        if (best > DIST_SAT)
            best = DIST_SAT;
        res.dist_sq = best[DIST_OUT_W-1:0];
        return res;
    endfunction

    // Applies one accepted command to the model. A compute queues its
    // prediction and then empties both sets and the drop flag.
    task automatic model_transfer(input logic [1:0] op, input logic [CELL_W-1:0] r,
                                  input logic [CELL_W-1:0] c);
        case (op)
            CMD_LOAD_A:
            begin
                if (fill_a < CELL_CAP)
                begin
                    set_a_row[fill_a] = r;
                    set_a_col[fill_a] = c;
                    fill_a++;
                end
                else
                    load_dropped = 1'b1;
            end
            CMD_LOAD_B:
            begin
                if (fill_b < CELL_CAP)
                begin
                    set_b_row[fill_b] = r;
                    set_b_col[fill_b] = c;
                    fill_b++;
                end
                else
                    load_dropped = 1'b1;
            end
            CMD_COMPUTE:
            begin
                pending_results.insert(pending_results.size(), nearest_corner_sq());
                fill_a = 0;
                fill_b = 0;
                load_dropped = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one command and returns at the edge where it is taken. Before the
    // offer the sender may sit idle for a random number of cycles, with noise
    // on the fields while start is low. start stays high on return so that
    // back-to-back commands need no gap.
    task automatic send_item(input logic [1:0] op, input logic [CELL_W-1:0] r,
                             input logic [CELL_W-1:0] c, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start    <= 1'b0;
            cmd      <= 2'($urandom);
            grid_row <= CELL_W'($urandom);
            grid_col <= CELL_W'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= op;
        grid_row <= r;
        grid_col <= c;
        do
            @(posedge clk);
        while (busy);
        model_transfer(op, r, c);
        if (op != CMD_UNUSED)
            cells_and_computes++;
    endtask

    // Holds the sender off until every predicted result has come back, then
    // lets the pipeline settle.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Mostly coordinates close to a base cell, so that distances are small
    // and often zero, with full-range values and the grid edges mixed in.
    function automatic logic [CELL_W-1:0] rand_coord(input logic [CELL_W-1:0] base);
        int v;
        case ($urandom_range(9))
            0, 1, 2:
                v = $urandom_range(int'(COORD_TOP));
            8:
                v = 0;
            9:
                v = int'(COORD_TOP);
            default:
                v = int'(base) + $urandom_range(6) - 3;
        endcase
        if (v < 0)
            v = 0;
        if (v > int'(COORD_TOP))
            v = int'(COORD_TOP);
        return CELL_W'(v);
    endfunction

    // One well-formed batch: random loads into both sets, interleaved, with
    // the odd ignored command thrown in, closed by a compute. Now and then a
    // set is left empty or a second compute follows straight away.
    task automatic run_batch(input int idle_pct, input int max_set);
        int                na;
        int                nb;
        logic [CELL_W-1:0] base_r;
        logic [CELL_W-1:0] base_c;
        logic [1:0]        op;
        na = ($urandom_range(15) == 0) ? 0 : $urandom_range(max_set, 1);
        nb = ($urandom_range(15) == 0) ? 0 : $urandom_range(max_set, 1);
        base_r = CELL_W'($urandom);
        base_c = CELL_W'($urandom);
        while (na > 0 || nb > 0)
        begin
            if ($urandom_range(11) == 0)
                send_item(CMD_UNUSED, CELL_W'($urandom), CELL_W'($urandom), idle_pct);
            if (nb == 0 || (na > 0 && $urandom_range(1) == 1))
            begin
                op = CMD_LOAD_A;
                na--;
            end
            else
            begin
                op = CMD_LOAD_B;
                nb--;
            end
            send_item(op, rand_coord(base_r), rand_coord(base_c), idle_pct);
        end
        send_item(CMD_COMPUTE, CELL_W'($urandom), CELL_W'($urandom), idle_pct);
        if ($urandom_range(19) == 0)
            send_item(CMD_COMPUTE, CELL_W'($urandom), CELL_W'($urandom), idle_pct);
    endtask

    // Loads n cells with full-range coordinates into one set.
    task automatic load_many(input logic [1:0] op, input int n);
        repeat (n)
            send_item(op, CELL_W'($urandom), CELL_W'($urandom), 0);
    endtask

    // Results are taken at the edge that ends their single valid cycle, so
    // the sample here sees the values the block held during that cycle.
    always @(posedge clk)
    begin : result_check
        dist_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with none expected: distance %0d",
                                          min_dist_squared));
            else
            begin
                want = pending_results.pop_front();
                if (min_dist_squared !== want.dist_sq)
                    report_mismatch($sformatf("min_dist_squared %0d, expected %0d",
                                              min_dist_squared, want.dist_sq));
                if (set_empty !== want.empty)
                    report_mismatch($sformatf("set_empty %0b, expected %0b",
                                              set_empty, want.empty));
                if (overflow !== want.ovf)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              overflow, want.ovf));
            end
        end
    end

    // Sender idle percentages for the three random phases.
    localparam int IDLE_PCT [3] = '{10, 76, 0};

    initial
    begin : stimulus
        int target;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed list. Where a row types its result, that value replaces
        // the prediction, so the block is held to the hand-worked values instead.
        for (int k = 0; k < N_ROWS; k++)
        begin
            send_item(STIM_ROWS[k].op, STIM_ROWS[k].row, STIM_ROWS[k].col, 10);
            if (STIM_ROWS[k].op == CMD_COMPUTE && STIM_ROWS[k].typed)
                pending_results[pending_results.size() - 1] =
                    '{STIM_ROWS[k].dist_sq, STIM_ROWS[k].empty, STIM_ROWS[k].ovf};
        end
        wait_results_drained();

        // Random batches under each sender pacing. Between phases the sender
        // waits for every outstanding result.
        for (int p = 0; p < 3; p++)
        begin
            target = cells_and_computes + 65;
            while (cells_and_computes < target)
                run_batch(IDLE_PCT[p], ($urandom_range(19) == 0) ? 32 : 8);
            wait_results_drained();
        end

        // Capacity case, sent back to back so the command queue fills behind
        // the compute: set A one past full, scanned in full against set B.
        load_many(CMD_LOAD_A, CELL_CAP + 1);
        load_many(CMD_LOAD_B, 2);
        send_item(CMD_COMPUTE, '0, '0, 0);
        // A short batch right behind the long scan checks that the sets and
        // the drop flag were cleared.
        run_batch(0, 4);
        wait_results_drained();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
